@@ hdl/deq_pkg.sv @@
// Shared types and codes for the double-ended queue core.
// No dependencies; imported by deq_ctrl and the top-level core.
package deq_pkg;

  // Command codes carried on the input channel
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Response control from sequencer to output register
  typedef struct packed {
    logic    load;      // write the output register this cycle
    logic    from_ram;  // value comes from the store read port
    status_t status;
  } rsp_ctl_t;

endpackage

@@ hdl/deq_if.sv @@
// Valid/ready channel interfaces for the double-ended queue core.
// No dependencies; the entry count width follows the CNT_W parameter of deq_out_if.
interface deq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface deq_out_if #(
  parameter int CNT_W = 11
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

@@ hdl/deq_ram.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on nothing; depth and address width come from the parent.
module deq_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/deq_ctrl.sv @@
// Command sequencer: front/back pointers, entry count and store access.
// Depends on deq_pkg; drives deq_ram and the output register in the top level.
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int CNT_W  = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_command,
  input  logic [31:0]       in_value,
  input  logic              out_free,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [31:0]       ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  output rsp_ctl_t          rsp,
  output logic [CNT_W-1:0]  rsp_count
);

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [ADDR_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              acc;
  logic              full, empty;
  logic [ADDR_W-1:0] front_inc, front_dec, back_inc, back_dec;
  status_t           st;
  cmd_t              cmd;

  assign cmd      = cmd_t'(in_command);
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  // circular neighbors of both pointers
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign back_inc  = (back_r == LAST_SLOT) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? LAST_SLOT : back_r - 1'b1;

  // next state: a store read holds the sequencer in S_READ
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc && ram_re) state_nxt = S_READ;
      S_READ:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command decode: pointer/count updates and store access
  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    st        = ST_OK;
    ram_we    = 1'b0;
    ram_waddr = front_dec;
    ram_wdata = in_value;
    ram_re    = 1'b0;
    ram_raddr = front_r;
    if (acc) begin
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            front_nxt = front_dec;
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            back_nxt  = back_inc;
            ram_we    = 1'b1;
            ram_waddr = back_r;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = front_r;
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = back_dec;
            back_nxt  = back_dec;
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_PEEK_FRONT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = front_r;
          end
        end
        CMD_PEEK_BACK: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = back_dec;
          end
        end
        CMD_SIZE: ;
        CMD_CLEAR: begin
          front_nxt = '0;
          back_nxt  = '0;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // response: in the accept cycle for non-reads, in the following cycle (S_READ) for store reads
  always_comb begin
    rsp.load     = (state_r == S_READ) || (acc && !ram_re);
    rsp.from_ram = (state_r == S_READ);
    rsp.status   = (state_r == S_READ) ? ST_OK : st;
    rsp_count    = (state_r == S_READ) ? count_r : count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/double_ended_queue_core.sv @@
// Double-ended queue core. Push, size, clear and error results reach the output register
// in the cycle after accept. Pop and peek results pass the store's read register first,
// and stall input. Throughput: one non-reading command per cycle unless output stalls.
// The output register lets a new word be accepted in the cycle the last result is taken.
// Reset clears pointers, count and valid; store contents are not cleared (no sweep).
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  deq_in_if.sink       in_ch,
  deq_out_if.source    out_ch
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic              out_free;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;
  rsp_ctl_t          rsp;
  logic [CNT_W-1:0]  rsp_count;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r;
  logic signed [31:0] value_r;
  logic [CNT_W-1:0]   ocount_r;

  assign out_free = !out_valid_r || out_ch.ready;

  deq_ctrl #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .in_value   (in_ch.push_value),
    .out_free   (out_free),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .rsp        (rsp),
    .rsp_count  (rsp_count)
  );

  deq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.load) begin
      status_r <= rsp.status;
      value_r  <= rsp.from_ram ? ram_rdata : '0;
      ocount_r <= rsp_count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.read_value  = value_r;
  assign out_ch.entry_count = ocount_r;

  // a result never overwrites a word that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.load |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over a pending output word");

  // a store read is answered in the following cycle
  a_read_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && ram_re) |=> (rsp.load && rsp.from_ram))
    else $error("store read not answered");

  // no input accepted while a store read is in flight
  a_read_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && ram_re) |=> !in_ch.ready)
    else $error("input accepted during store read");

  // occupancy stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ocount_r <= CNT_W'(DEPTH)))
    else $error("entry count beyond depth");

endmodule
